>>> rtl/core/pfa_pkg.sv
// shared constants, widths and codes for the page frame allocator
package pfa_pkg;

  // pool geometry
  localparam int FRAME_COUNT = 8192;
  localparam int FRAME_SHIFT = 12;
  localparam int ADDR_W      = 56;
  localparam int BASE_W      = 44;
  localparam int OUT_IDX_W   = 13;

  // map words: one row of the bitmap memory holds WORD_W frame marks
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int ROW_COUNT = (FRAME_COUNT + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int IDX_W     = ROW_W + BIT_W;
  localparam int IDXX_W    = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

  // row summary flags are scanned WORD_W at a time
  localparam int GRP_COUNT = (ROW_COUNT + WORD_W - 1) / WORD_W;
  localparam int GRP_IW    = (GRP_COUNT > 1) ? $clog2(GRP_COUNT) : 1;
  localparam int AVAIL_LEN = GRP_COUNT * WORD_W;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // marks of the last row that lie past the end of the pool
  function automatic logic [WORD_W-1:0] last_row_pad();
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if ((ROW_COUNT - 1) * WORD_W + b >= FRAME_COUNT) m[b] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [WORD_W-1:0] LAST_ROW_PAD = last_row_pad();

endpackage

>>> rtl/core/pfa_ffs.sv
// shared find-first-set unit: lowest set bit of one map word
module pfa_ffs (
  input  logic [pfa_pkg::WORD_W-1:0] vec,
  output logic                       found,
  output logic [pfa_pkg::BIT_W-1:0]  pos
);
  import pfa_pkg::*;

  // scan from the top so the lowest set bit wins
  always_comb begin
    found = |vec;
    pos   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (vec[i]) pos = BIT_W'(i);
    end
  end

endmodule

>>> rtl/core/page_frame_allocator.sv
// first-fit bitmap allocator for fixed 4096-byte page frames
//
// Input channel (in_valid/in_ready): in_kind selects allocate or free,
// in_free_address carries the frame address for a free. Output channel
// (out_valid/out_ready) returns one result transaction per request:
// frame address, frame index and status. cfg_wr_en/cfg_wr_data set the
// pool base page number; write it only while no request is in flight.
//
// The map lives in a memory of 64-bit rows, read one row at a time, with
// a flag per row that says whether the row still has a free frame. An
// allocate first scans those flags 64 rows per cycle, then reads the row
// and picks the lowest free bit; both scans share one find-first-set unit.
// An allocate scans 1 to ceil(rows / 64) flag groups, 1 to 2 for 8192
// frames, and a full pool answers after it has scanned them all. A
// free reads the row and writes it back with the frame's bit cleared;
// an address outside the pool is answered right after the range check.
// One request is handled at a time: in_ready is low from the
// transaction until the result is taken, and a stalled receiver simply
// holds the block with its result on the output.
// Reset marks every frame free at once through per-row valid bits; no
// clearing pass is needed and requests are taken right after reset.
module page_frame_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [pfa_pkg::BASE_W-1:0]      cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [pfa_pkg::ADDR_W-1:0]      in_free_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pfa_pkg::ADDR_W-1:0]      out_frame_address,
  output logic [pfa_pkg::OUT_IDX_W-1:0]   out_frame_index,
  output logic [1:0]                      out_status
);
  import pfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GRP,
    S_RD,
    S_ALLOC,
    S_ADDR,
    S_FCHK,
    S_FRD,
    S_FWR,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0]    base_r;
  logic [GRP_IW-1:0]    grp_r, grp_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [ADDR_W:0]      diff_r, diff_nxt;
  logic                 in_ready_r, in_ready_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [1:0]           out_st_r, out_st_nxt;

  // map storage and row summary
  logic [WORD_W-1:0]    map_mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] row_valid_r;
  logic [AVAIL_LEN-1:0] avail_r;
  logic [WORD_W-1:0]    rd_data_r;
  logic                 rd_valid_r;

  logic                 mem_we;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 avail_we;
  logic                 avail_val;

  logic [ADDR_W-1:0]    base_addr;
  logic [WORD_W-1:0]    row_word;
  logic [WORD_W-1:0]    ffs_vec;
  logic                 ffs_found;
  logic [BIT_W-1:0]     ffs_pos;
  logic [GRP_IW+BIT_W-1:0] hit_row;
  logic [IDX_W-1:0]     alloc_idx;
  logic [IDXX_W-1:0]    idx_ext;
  logic [BASE_W-1:0]    free_idx;
  logic [WORD_W-1:0]    bit_mask;

  assign base_addr = {base_r, FRAME_SHIFT'(0)};

  // current row as stored, with past-the-end frames shown as used
  assign row_word = (rd_valid_r ? rd_data_r : '0) |
                    ((row_r == ROW_W'(ROW_COUNT - 1)) ? LAST_ROW_PAD : '0);

  // shared search unit: row flags while scanning groups, free bits otherwise
  assign ffs_vec = (state_r == S_GRP) ? avail_r[{grp_r, BIT_W'(0)} +: WORD_W]
                                      : ~row_word;

  pfa_ffs u_ffs (
    .vec   (ffs_vec),
    .found (ffs_found),
    .pos   (ffs_pos)
  );

  assign hit_row   = {grp_r, ffs_pos};
  assign alloc_idx = {row_r, ffs_pos};
  assign idx_ext   = IDXX_W'(idx_r);
  assign free_idx  = diff_r[ADDR_W-1:FRAME_SHIFT];
  assign bit_mask  = WORD_W'(1) << bit_r;

  // pool base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  // bitmap memory, one row read every cycle
  always_ff @(posedge clk) begin
    if (mem_we) map_mem[row_r] <= mem_wdata;
    rd_data_r <= map_mem[row_r];
  end

  // row valid bits cleared and free-frame flags set by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
      for (int i = 0; i < AVAIL_LEN; i++) avail_r[i] <= (i < ROW_COUNT);
    end else begin
      rd_valid_r <= row_valid_r[row_r];
      if (mem_we) row_valid_r[row_r] <= 1'b1;
      if (avail_we) avail_r[row_r] <= avail_val;
    end
  end

  // sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    grp_nxt       = grp_r;
    row_nxt       = row_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    diff_nxt      = diff_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_wdata     = row_word;
    avail_we      = 1'b0;
    avail_val     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_ready_nxt = 1'b0;
          grp_nxt      = '0;
          diff_nxt     = {1'b0, in_free_address} - {1'b0, base_addr};
          state_nxt    = (in_kind == KIND_ALLOC) ? S_GRP : S_FCHK;
        end
      end
      // look for a row that still has a free frame
      S_GRP: begin
        if (ffs_found) begin
          row_nxt   = hit_row[ROW_W-1:0];
          state_nxt = S_RD;
        end else if (grp_r == GRP_IW'(GRP_COUNT - 1)) begin
          out_addr_nxt  = '0;
          out_idx_nxt   = '0;
          out_st_nxt    = ST_FULL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      S_RD: begin
        state_nxt = S_ALLOC;
      end
      // take the lowest free frame of the row
      S_ALLOC: begin
        mem_we    = 1'b1;
        mem_wdata = row_word | (WORD_W'(1) << ffs_pos);
        avail_we  = 1'b1;
        avail_val = ~&mem_wdata;
        idx_nxt   = alloc_idx;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        out_addr_nxt  = base_addr + ADDR_W'({idx_r, FRAME_SHIFT'(0)});
        out_idx_nxt   = idx_ext[OUT_IDX_W-1:0];
        out_st_nxt    = ST_OK;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      // range check of a free request
      S_FCHK: begin
        if (diff_r[ADDR_W] || (free_idx >= BASE_W'(FRAME_COUNT))) begin
          out_addr_nxt  = '0;
          out_idx_nxt   = '0;
          out_st_nxt    = ST_OUTSIDE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          row_nxt   = free_idx[IDX_W-1:BIT_W];
          bit_nxt   = free_idx[BIT_W-1:0];
          idx_nxt   = free_idx[IDX_W-1:0];
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        state_nxt = S_FWR;
      end
      S_FWR: begin
        mem_we        = 1'b1;
        mem_wdata     = row_word & ~bit_mask;
        avail_we      = 1'b1;
        avail_val     = 1'b1;
        out_addr_nxt  = '0;
        out_idx_nxt   = idx_ext[OUT_IDX_W-1:0];
        out_st_nxt    = ST_OK;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          in_ready_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    grp_r      <= grp_nxt;
    row_r      <= row_nxt;
    bit_r      <= bit_nxt;
    idx_r      <= idx_nxt;
    diff_r     <= diff_nxt;
    out_addr_r <= out_addr_nxt;
    out_idx_r  <= out_idx_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_ready          = in_ready_r;
  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_frame_index   = out_idx_r;
  assign out_status        = out_st_r;

endmodule

>>> rtl/core/pfa_checker.sv
// port-level checks for the page frame allocator, bound to the top level
module pfa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pfa_pkg::ADDR_W-1:0]      out_frame_address,
  input logic [pfa_pkg::OUT_IDX_W-1:0]   out_frame_index,
  input logic [1:0]                      out_status
);
  import pfa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_address) &&
      $stable(out_frame_index) && $stable(out_status))
    else $error("stalled result changed");

  // one request in flight: no new transaction while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // a transaction closes the input and never answers in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not busy after a request");

  // rejected or full results carry no frame
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_OUTSIDE) |->
      out_frame_address == '0 && out_frame_index == '0)
    else $error("failed result carries a frame");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_FULL ||
      out_status == ST_OUTSIDE)
    else $error("undefined status code");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);

>>> dv/page_frame_allocator_tb.sv
// testbench for the page frame allocator: directed and random requests against a scoreboard
`timescale 1ns / 1ps

module page_frame_allocator_tb;
  import pfa_pkg::*;

  // cycles with no transaction on either channel before the run is declared hung;
  // the slowest correct gap comes from scan, stall bursts, drain or config
  localparam int STALL_LIMIT = 2000;

  localparam logic [BASE_W-1:0] BASE_TOP = '1;
  localparam logic [BASE_W-1:0] BASE_MID = 44'h123_4567_89ab;
  // last frame of the pool ends exactly at the top of the address space
  localparam logic [BASE_W-1:0] BASE_AT_END = BASE_TOP - (FRAME_COUNT - 1);

  typedef struct packed {
    logic [ADDR_W-1:0]    frame_address;
    logic [OUT_IDX_W-1:0] frame_index;
    logic [1:0]           status;
  } frame_result_t;

  // frame map predictor and queue of expected results
  class frame_scoreboard;
    bit                used_map [FRAME_COUNT];
    int                first_free = 0;   // no free frame below this index
    int                high_mark = 0;    // highest frame ever allocated
    logic [BASE_W-1:0] base_page = '0;
    frame_result_t     expected_q [$];
    int                mismatch_count = 0;

    function int pending();
      return expected_q.size();
    endfunction

    // predict the result of one accepted request and update the map
    function void note_request(logic kind, logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] base_addr;
      logic [ADDR_W-1:0] page_off;
      logic [ADDR_W-1:0] step;
      frame_result_t     res;
      int                i;
      base_addr = {base_page, {FRAME_SHIFT{1'b0}}};
      res = '0;
      res.status = ST_OK;
      if (kind == KIND_ALLOC) begin
        i = first_free;
        while (i < FRAME_COUNT && used_map[i]) i++;
        first_free = i;
        if (i == FRAME_COUNT) begin
          res.status = ST_FULL;
        end else begin
          used_map[i] = 1'b1;
          first_free = i + 1;
          if (i > high_mark) high_mark = i;
          step = ADDR_W'(i);
          res.frame_address = base_addr + (step << FRAME_SHIFT);
          res.frame_index = i[OUT_IDX_W-1:0];
        end
      end else if (addr < base_addr) begin
        res.status = ST_OUTSIDE;
      end else begin
        page_off = (addr - base_addr) >> FRAME_SHIFT;
        if (page_off >= FRAME_COUNT) begin
          res.status = ST_OUTSIDE;
        end else begin
          used_map[page_off] = 1'b0;
          if (page_off < first_free) first_free = int'(page_off);
          res.frame_index = page_off[OUT_IDX_W-1:0];
        end
      end
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // compare one result transaction with the oldest expectation
    task check_result(logic [ADDR_W-1:0] addr, logic [OUT_IDX_W-1:0] idx, logic [1:0] st);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result addr=%h index=%0d status=%0d",
                                  addr, idx, st));
      end else begin
        want = expected_q.pop_front();
        if (addr !== want.frame_address)
          report_mismatch($sformatf("frame_address got %h expected %h",
                                    addr, want.frame_address));
        if (idx !== want.frame_index)
          report_mismatch($sformatf("frame_index got %0d expected %0d",
                                    idx, want.frame_index));
        if (st !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", st, want.status));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [BASE_W-1:0]    cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_kind;
  logic [ADDR_W-1:0]    in_free_address;
  logic                 out_valid;
  logic                 out_ready;
  logic [ADDR_W-1:0]    out_frame_address;
  logic [OUT_IDX_W-1:0] out_frame_index;
  logic [1:0]           out_status;

  frame_scoreboard sb;
  bit              idling_on;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  logic [63:0]     wide_rand;

  page_frame_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_address (out_frame_address),
    .out_frame_index   (out_frame_index),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // address of a frame in the current pool, with an offset inside the frame
  function automatic logic [ADDR_W-1:0] frame_addr(longint unsigned idx, logic [11:0] off);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(idx);
    return {sb.base_page, {FRAME_SHIFT{1'b0}}} + (a << FRAME_SHIFT) + ADDR_W'(off);
  endfunction

  // present one request and hold it until the transaction
  task automatic send_request(logic kind, logic [ADDR_W-1:0] addr);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_free_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(kind, addr);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_base(logic [BASE_W-1:0] page);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= page;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.base_page = page;
  endtask

  // mostly allocations and frees of plausible frames, with some stray addresses
  task automatic run_random(int count);
    int                pick;
    int                idx;
    logic [63:0]       noise;
    logic [ADDR_W-1:0] base_addr;
    base_addr = {sb.base_page, {FRAME_SHIFT{1'b0}}};
    for (int n = 0; n < count; n++) begin
      pick  = $urandom_range(0, 99);
      noise = {$urandom, $urandom};
      if (pick < 45) begin
        send_request(KIND_ALLOC, noise[ADDR_W-1:0]);
      end else if (pick < 80) begin
        idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 127)
                                          : $urandom_range(0, sb.high_mark);
        send_request(KIND_FREE,
                     frame_addr(idx, ($urandom_range(0, 1) == 0) ? 12'h000 : noise[11:0]));
      end else if (pick < 88) begin
        send_request(KIND_FREE, noise[ADDR_W-1:0]);
      end else if (pick < 94) begin
        send_request(KIND_FREE, base_addr - 1 - noise[15:0]);
      end else begin
        send_request(KIND_FREE, frame_addr(FRAME_COUNT + $urandom_range(0, 3), noise[11:0]));
      end
    end
    drain_results();
  endtask

  // result side: check every result transaction, stall in random bursts while idling is on
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_frame_address, out_frame_index, out_status);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: too long without any transaction means the block is hung
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("page_frame_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    sb = new();
    idling_on = 1'b1;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_kind         <= KIND_ALLOC;
    in_free_address <= '0;
    out_ready       <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // base at zero: frame 0 sits at address 0, double, unaligned and out-of-pool frees
    send_request(KIND_ALLOC, '0);
    send_request(KIND_ALLOC, '1);
    send_request(KIND_FREE, '0);
    send_request(KIND_FREE, '0);
    send_request(KIND_FREE, 56'h1fff);
    send_request(KIND_FREE, frame_addr(FRAME_COUNT, 12'h000));
    send_request(KIND_FREE, '1);
    send_request(KIND_ALLOC, '0);
    drain_results();

    // base at the top: frame addresses wrap around and frees of a wrapped address are rejected
    write_base(BASE_TOP);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, '0);
    send_request(KIND_FREE, frame_addr(0, 12'habc));
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, frame_addr(1, 12'h000));
    drain_results();

    // mid base: below the pool, last frame, one past the end
    write_base(BASE_MID);
    send_request(KIND_FREE, '0);
    send_request(KIND_FREE, frame_addr(FRAME_COUNT - 1, 12'hfff));
    send_request(KIND_FREE, frame_addr(FRAME_COUNT, 12'h000));
    send_request(KIND_FREE, frame_addr(1, 12'h000));
    send_request(KIND_FREE, frame_addr(2, 12'h000));
    send_request(KIND_ALLOC, '0);

    // allocate across the first map rows, then free frames in and past them and refill
    repeat (120) send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, frame_addr(FRAME_COUNT / 2, 12'h000));
    send_request(KIND_FREE, frame_addr(63, 12'h000));
    send_request(KIND_FREE, frame_addr(64, 12'h800));
    send_request(KIND_FREE, frame_addr(FRAME_COUNT - 1, 12'h000));
    repeat (5) send_request(KIND_ALLOC, '0);
    drain_results();

    // random traffic over several pool bases
    write_base('0);
    run_random(70);
    write_base(BASE_TOP);
    run_random(50);
    wide_rand = {$urandom, $urandom};
    write_base(wide_rand[BASE_W-1:0]);
    run_random(70);
    write_base(BASE_AT_END);
    run_random(50);
    write_base(BASE_W'($urandom_range(1, 1000)));
    idling_on = 1'b0;
    run_random(110);

    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("page_frame_allocator_tb: PASS");
    end else begin
      $display("page_frame_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
